@@ src/bfs_top_down_csr_unit_defines.svh @@
// assertion macros shared by the checker of the search block
// depends on clk and arst_n being visible where a macro is used
`ifndef BFS_TOP_DOWN_CSR_UNIT_DEFINES_SVH
`define BFS_TOP_DOWN_CSR_UNIT_DEFINES_SVH

// property that must hold at every edge outside reset
`define BTD_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("btd: property violated");

// implication checked in the following cycle
`define BTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("btd: next-cycle property violated");

`endif

@@ src/btd_pkg.sv @@
// types and constants of the breadth-first search block
// no dependencies
package btd_pkg;

	localparam logic [1:0] OP_LOAD_ROW  = 2'd0;
	localparam logic [1:0] OP_LOAD_EDGE = 2'd1;
	localparam logic [1:0] OP_RUN       = 2'd2;
	localparam logic [1:0] OP_QUERY     = 2'd3;

	localparam logic [10:0] VCOUNT_RESET = 11'd1024;
	localparam logic signed [10:0] PARENT_NONE = -11'sd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  vertex_id;
		logic [12:0] row_start;
		logic [13:0] row_degree;
		logic [12:0] edge_slot;
		logic [9:0]  edge_target;
	} item_t;

	typedef struct packed {
		logic signed [10:0] parent_of;
		logic [10:0]        reached_total;
		logic [10:0]        level_total;
		logic               source_error;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load_row;
		logic load_edge;
		logic clr_start;
		logic clr_step;
		logic run_init;
		logic seed;
		logic level_mark;
		logic pop;
		logic row_rd;
		logic row_take;
		logic edge_rd;
		logic u_take;
		logic claim;
		logic level_inc;
		logic q_sel;
		logic res_run;
		logic res_query;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic src_bad;
		logic head_lt_tail;
		logic head_lt_lend;
		logic edge_more;
		logic u_ok;
		logic parent_free;
	} status_t;

endpackage

@@ src/btd_ram.sv @@
// generic single write, single read RAM with registered read data
// no dependencies
module btd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/btd_ctrl.sv @@
// controller state machine of the search block
// depends on btd_pkg
module btd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      operation,
	input  btd_pkg::status_t st,
	output logic            busy,
	output btd_pkg::cmd_t   cmd
);
	import btd_pkg::*;

	typedef enum logic [3:0] {
		S_CLR_INIT, S_IDLE, S_CLR_RUN, S_SEED, S_LEVEL, S_POP, S_ROW, S_ROWW,
		S_EDGE, S_EDGEW, S_PCHK, S_QRD, S_QOUT
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR_INIT: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					case (operation)
						OP_LOAD_ROW:  cmd.load_row = 1'b1;
						OP_LOAD_EDGE: cmd.load_edge = 1'b1;
						OP_RUN: begin
							cmd.clr_start = 1'b1;
							cmd.run_init  = 1'b1;
							state_d       = S_CLR_RUN;
						end
						OP_QUERY: state_d = S_QRD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLR_RUN: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_SEED;
			end
			S_SEED: begin
				if (st.src_bad) begin
					cmd.res_run = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.seed = 1'b1;
					state_d  = S_LEVEL;
				end
			end
			S_LEVEL: begin
				if (st.head_lt_tail) begin
					cmd.level_mark = 1'b1;
					state_d        = S_POP;
				end else begin
					cmd.res_run = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_POP: begin
				if (st.head_lt_lend) begin
					cmd.pop = 1'b1;
					state_d = S_ROW;
				end else begin
					cmd.level_inc = 1'b1;
					state_d       = S_LEVEL;
				end
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				state_d    = S_ROWW;
			end
			S_ROWW: begin
				cmd.row_take = 1'b1;
				state_d      = S_EDGE;
			end
			S_EDGE: begin
				if (st.edge_more) begin
					cmd.edge_rd = 1'b1;
					state_d     = S_EDGEW;
				end else begin
					state_d = S_POP;
				end
			end
			S_EDGEW: begin
				cmd.u_take = 1'b1;
				state_d    = st.u_ok ? S_PCHK : S_EDGE;
			end
			S_PCHK: begin
				cmd.claim = st.parent_free;
				state_d   = S_EDGE;
			end
			S_QRD: begin
				cmd.q_sel = 1'b1;
				state_d   = S_QOUT;
			end
			S_QOUT: begin
				cmd.res_query = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register, parent store swept after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_INIT;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ src/btd_datapath.sv @@
// stores, queue pointers, counters and result register of the search block
// depends on btd_pkg and btd_ram
module btd_datapath #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  btd_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [10:0]      cfg_wdata,
	input  btd_pkg::cmd_t    cmd,
	output btd_pkg::status_t st,
	output logic             done,
	output btd_pkg::result_t result
);
	import btd_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int CW  = (VAW + 1 > 11) ? VAW + 1 : 11;

	logic [10:0]    vcount_q;
	logic [9:0]     vid_q, v_q, u_q;
	logic [VAW:0]   head_q, tail_q, lend_q;
	logic [CW-1:0]  reached_q, levels_q;
	logic [VAW-1:0] clr_q;
	logic [14:0]    j_q, stop_q;
	logic           done_q;
	result_t        result_q;

	logic [31:0] vid_in32, slot32, vidq32, qd32, ed32, j32, u32;
	logic [26:0] row_rdata;
	logic [9:0]  q_rdata, e_rdata;
	logic [10:0] p_rdata;

	logic           row_we, edge_we, par_we, que_we;
	logic [VAW-1:0] row_waddr, par_waddr, par_raddr, que_waddr, row_raddr;
	logic [10:0]    par_wdata;
	logic [9:0]     que_wdata;
	logic [EAW-1:0] edge_waddr, edge_raddr;

	assign vid_in32 = 32'(item.vertex_id);
	assign slot32   = 32'(item.edge_slot);
	assign vidq32   = 32'(vid_q);
	assign qd32     = 32'(q_rdata);
	assign ed32     = 32'(e_rdata);
	assign j32      = 32'(j_q);
	assign u32      = 32'(u_q);

	// status towards the controller
	assign st.clr_last     = (clr_q == VAW'(MAX_VERTICES - 1));
	assign st.src_bad      = !((vidq32 < 32'(vcount_q)) && (vidq32 < MAX_VERTICES));
	assign st.head_lt_tail = (head_q < tail_q);
	assign st.head_lt_lend = (head_q < lend_q);
	assign st.edge_more    = (j_q < stop_q) && (j32 < MAX_EDGES);
	assign st.u_ok         = (ed32 < 32'(vcount_q)) && (ed32 < MAX_VERTICES);
	assign st.parent_free  = p_rdata[10];

	// row store write and read
	assign row_we    = cmd.load_row && (vid_in32 < MAX_VERTICES);
	assign row_waddr = vid_in32[VAW-1:0];
	assign row_raddr = qd32[VAW-1:0];

	btd_ram #(.WIDTH(27), .DEPTH(MAX_VERTICES)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_waddr),
		.wdata({item.row_start, item.row_degree}),
		.raddr(row_raddr), .rdata(row_rdata)
	);

	// edge store
	assign edge_we    = cmd.load_edge && (slot32 < MAX_EDGES);
	assign edge_waddr = slot32[EAW-1:0];
	assign edge_raddr = j32[EAW-1:0];

	btd_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(item.edge_target),
		.raddr(edge_raddr), .rdata(e_rdata)
	);

	// parent store: sweep, seed and claim writes
	always_comb begin
		par_we    = cmd.clr_step || cmd.seed || cmd.claim;
		par_waddr = clr_q;
		par_wdata = PARENT_NONE;
		if (cmd.claim) begin
			par_waddr = u32[VAW-1:0];
			par_wdata = {1'b0, v_q};
		end else if (cmd.seed) begin
			par_waddr = vidq32[VAW-1:0];
			par_wdata = {1'b0, vid_q};
		end
	end
	assign par_raddr = cmd.q_sel ? vidq32[VAW-1:0] : ed32[VAW-1:0];

	btd_ram #(.WIDTH(11), .DEPTH(MAX_VERTICES)) u_parent_ram (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(par_raddr), .rdata(p_rdata)
	);

	// frontier queue
	assign que_we    = cmd.seed || (cmd.claim && (32'(tail_q) < MAX_VERTICES));
	assign que_waddr = cmd.seed ? '0 : tail_q[VAW-1:0];
	assign que_wdata = cmd.seed ? vid_q : u_q;

	btd_ram #(.WIDTH(10), .DEPTH(MAX_VERTICES)) u_queue_ram (
		.clk(clk), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
		.raddr(head_q[VAW-1:0]), .rdata(q_rdata)
	);

	// configuration, counters and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q  <= VCOUNT_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			lend_q    <= '0;
			reached_q <= '0;
			levels_q  <= '0;
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.run_init) begin
				head_q    <= '0;
				tail_q    <= '0;
				lend_q    <= '0;
				reached_q <= '0;
				levels_q  <= '0;
			end
			if (cmd.seed) begin
				tail_q    <= (VAW + 1)'(1);
				reached_q <= CW'(1);
			end
			if (cmd.level_mark) lend_q <= tail_q;
			if (cmd.pop) head_q <= head_q + 1'b1;
			if (cmd.level_inc) levels_q <= levels_q + 1'b1;
			if (cmd.claim) begin
				reached_q <= reached_q + 1'b1;
				if (32'(tail_q) < MAX_VERTICES) tail_q <= tail_q + 1'b1;
			end
			done_q <= cmd.res_run || cmd.res_query;
		end
	end

	// payload registers for the walk and the result
	always_ff @(posedge clk) begin
		if (cmd.take) vid_q <= item.vertex_id;
		if (cmd.row_rd) v_q <= q_rdata;
		if (cmd.row_take) begin
			j_q    <= {2'b00, row_rdata[26:14]};
			stop_q <= 15'({2'b00, row_rdata[26:14]}) + 15'({1'b0, row_rdata[13:0]});
		end
		if (cmd.edge_rd) j_q <= j_q + 1'b1;
		if (cmd.u_take) u_q <= e_rdata;
		if (cmd.res_run || cmd.res_query) begin
			result_q.reached_total <= reached_q[10:0];
			result_q.level_total   <= levels_q[10:0];
			result_q.source_error  <= cmd.res_run && st.src_bad;
			result_q.parent_of     <= '0;
			if (cmd.res_query) begin
				result_q.parent_of <= (vidq32 < MAX_VERTICES) ? p_rdata : PARENT_NONE;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

@@ src/bfs_top_down_csr_unit.sv @@
// top level of the top-down breadth-first search block over a CSR graph
// depends on btd_pkg, btd_ctrl, btd_datapath
//
// A request is taken when start is high and busy is low. Row and edge loads leave busy
// low, so loads may follow every cycle. A query passes through S_QRD and S_QOUT before
// its result is registered. A run first sweeps the parent store, then walks the frontier:
// each popped vertex passes S_POP, S_ROW and S_ROWW, and each edge S_EDGE, S_EDGEW and,
// for a valid target, S_PCHK. After reset the same parent sweep runs with busy high.
// A result is shown for one cycle with done high and cannot be held off by the
// receiver.
module bfs_top_down_csr_unit #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  btd_pkg::item_t   item,
	output logic             done,
	output btd_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [10:0]      cfg_wdata
);
	import btd_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencing
	btd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(item.operation),
		.st(st), .busy(busy), .cmd(cmd)
	);

	// stores and counters
	btd_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .cmd(cmd), .st(st), .done(done), .result(result)
	);
endmodule

@@ src/btd_checker.sv @@
// port-level checks of the search block, bound to the top level
// depends on btd_pkg and bfs_top_down_csr_unit_defines.svh
`include "bfs_top_down_csr_unit_defines.svh"
module btd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input btd_pkg::item_t   item,
	input logic             done,
	input btd_pkg::result_t result,
	input logic             cfg_we,
	input logic [10:0]      cfg_wdata
);
	import btd_pkg::*;

	logic load_acc, long_acc, err_res, totals_zero;

	assign load_acc = start && !busy &&
		(item.operation == OP_LOAD_ROW || item.operation == OP_LOAD_EDGE);
	assign long_acc = start && !busy &&
		(item.operation == OP_RUN || item.operation == OP_QUERY);
	assign err_res     = done && result.source_error;
	assign totals_zero = (result.reached_total == 11'd0) && (result.level_total == 11'd0);

	// loads leave the block free
	`BTD_ASSERT_NEXT(a_load_free, load_acc, !busy)
	// runs and queries hold the block
	`BTD_ASSERT_NEXT(a_long_busy, long_acc, busy)
	// results never come in adjacent cycles
	`BTD_ASSERT_NEXT(a_done_single, done, !done)
	// a rejected source reaches nothing
	`BTD_ASSERT(a_err_empty, !err_res || totals_zero)
endmodule

bind bfs_top_down_csr_unit btd_checker u_btd_checker (.*);
